// ----- rtl/thread_table_scheduler_unit_assert.svh -----
// Assertion helpers used by the scheduler datapath.
`ifndef THREAD_TABLE_SCHEDULER_UNIT_ASSERT_SVH
`define THREAD_TABLE_SCHEDULER_UNIT_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define TTS_CHECK_SAME(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define TTS_CHECK_NEXT(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/tts_pkg.sv -----
package tts_pkg;

  // Operation codes carried in the kind field
  typedef enum logic [2:0] {
    OP_CREATE    = 3'd0,
    OP_SCHEDULE  = 3'd1,
    OP_YIELD     = 3'd2,
    OP_EXIT      = 3'd3,
    OP_KILL      = 3'd4,
    OP_WAIT      = 3'd5,
    OP_SIGNAL    = 3'd6,
    OP_BROADCAST = 3'd7
  } kind_t;

  // Slot status codes
  localparam logic [2:0] ST_UNUSED   = 3'd0;
  localparam logic [2:0] ST_READY    = 3'd1;
  localparam logic [2:0] ST_RUNNING  = 3'd2;
  localparam logic [2:0] ST_SLEEPING = 3'd3;
  localparam logic [2:0] ST_ZOMBIE   = 3'd4;
  localparam logic [2:0] ST_STOP     = 3'd5;

  // Outcome codes
  localparam logic [1:0] OUT_OK    = 2'd0;
  localparam logic [1:0] OUT_NONE  = 2'd1;
  localparam logic [1:0] OUT_NOCUR = 2'd2;

  typedef struct packed {
    logic [2:0]  kind;
    logic [3:0]  thread_id;
    logic [15:0] wait_tag;
  } in_t;

  typedef struct packed {
    logic [3:0] result_thread;
    logic       found;
    logic [1:0] outcome;
  } out_t;

  // One slot of the thread table
  typedef struct packed {
    logic [2:0]  status;
    logic [7:0]  slice;
    logic [15:0] tag;
  } entry_t;

  // Source of a slot table write
  typedef enum logic [2:0] {
    WSRC_NONE = 3'd0,
    WSRC_SCAN = 3'd1,
    WSRC_CUR  = 3'd2,
    WSRC_PICK = 3'd3,
    WSRC_MOD  = 3'd4
  } wsrc_t;

  // Result to record for the transaction
  typedef enum logic [2:0] {
    RES_OK       = 3'd0,
    RES_NONE     = 3'd1,
    RES_NOCUR    = 3'd2,
    RES_HIT_EVAL = 3'd3,
    RES_HIT_PICK = 3'd4
  } res_t;

  typedef struct packed {
    logic  load;
    logic  scan;
    wsrc_t wr_src;
    logic  res_we;
    res_t  res;
    logic  out_load;
  } cmd_t;

  typedef struct packed {
    logic cur_valid;
    logic kill_ok;
    logic scan_end;
    logic scan_stop;
    logic hit;
    logic out_free;
  } sts_t;

endpackage

// ----- rtl/tts_ctrl.sv -----
module tts_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic [2:0]    in_kind,
  input  tts_pkg::sts_t sts,
  output tts_pkg::cmd_t cmd,
  output logic          in_stall
);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_SCAN = 7'b0000010,
    S_RD   = 7'b0000100,
    S_WR   = 7'b0001000,
    S_FIX  = 7'b0010000,
    S_PICK = 7'b0100000,
    S_DONE = 7'b1000000
  } state_t;

  state_t          state;
  state_t          state_next;
  tts_pkg::kind_t  op_kind;
  tts_pkg::kind_t  in_op;

  assign in_op    = tts_pkg::kind_t'(in_kind);
  assign in_stall = (state != S_IDLE);

  // Latch the operation of an accepted transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      op_kind <= tts_pkg::OP_CREATE;
    end else begin
      state <= state_next;
      if (cmd.load) begin
        op_kind <= in_op;
      end
    end
  end

  // Sequence the datapath
  always_comb begin
    state_next   = state;
    cmd.load     = 1'b0;
    cmd.scan     = 1'b0;
    cmd.wr_src   = tts_pkg::WSRC_NONE;
    cmd.res_we   = 1'b0;
    cmd.res      = tts_pkg::RES_OK;
    cmd.out_load = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          unique case (in_op)
            tts_pkg::OP_CREATE, tts_pkg::OP_SCHEDULE,
            tts_pkg::OP_SIGNAL, tts_pkg::OP_BROADCAST: begin
              state_next = S_SCAN;
            end
            tts_pkg::OP_YIELD, tts_pkg::OP_EXIT, tts_pkg::OP_WAIT: begin
              if (sts.cur_valid) begin
                state_next = S_RD;
              end else begin
                cmd.res_we = 1'b1;
                cmd.res    = tts_pkg::RES_NOCUR;
                state_next = S_DONE;
              end
            end
            tts_pkg::OP_KILL: begin
              if (sts.kill_ok) begin
                state_next = S_RD;
              end else begin
                cmd.res_we = 1'b1;
                cmd.res    = tts_pkg::RES_NONE;
                state_next = S_DONE;
              end
            end
          endcase
        end
      end
      S_SCAN: begin
        cmd.scan   = 1'b1;
        cmd.wr_src = tts_pkg::WSRC_SCAN;
        if (sts.scan_stop) begin
          cmd.res_we = 1'b1;
          cmd.res    = tts_pkg::RES_HIT_EVAL;
          state_next = S_DONE;
        end else if (sts.scan_end) begin
          if (op_kind == tts_pkg::OP_SCHEDULE && sts.hit) begin
            state_next = S_FIX;
          end else begin
            cmd.res_we = 1'b1;
            cmd.res    = sts.hit ? tts_pkg::RES_HIT_PICK : tts_pkg::RES_NONE;
            state_next = S_DONE;
          end
        end
      end
      S_RD: begin
        state_next = S_WR;
      end
      S_WR: begin
        cmd.wr_src = tts_pkg::WSRC_MOD;
        cmd.res_we = 1'b1;
        cmd.res    = tts_pkg::RES_OK;
        state_next = S_DONE;
      end
      S_FIX: begin
        cmd.wr_src = tts_pkg::WSRC_CUR;
        state_next = S_PICK;
      end
      S_PICK: begin
        cmd.wr_src = tts_pkg::WSRC_PICK;
        cmd.res_we = 1'b1;
        cmd.res    = tts_pkg::RES_HIT_PICK;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ----- rtl/tts_dp.sv -----
`include "thread_table_scheduler_unit_assert.svh"

module tts_dp #(
  parameter int SLOTS = 16
) (
  input  logic            clk,
  input  logic            rst,
  input  tts_pkg::in_t    in_data,
  input  logic            cfg_we,
  input  logic [7:0]      cfg_wdata,
  input  tts_pkg::cmd_t   cmd,
  output tts_pkg::sts_t   sts,
  input  logic            out_stall,
  output logic            out_valid,
  output tts_pkg::out_t   out_data
);

  localparam int IDX_W = $clog2(SLOTS);
  localparam int CNT_W = $clog2(SLOTS + 1);

  // Slot table memory with per-slot valid bits
  tts_pkg::entry_t    mem [SLOTS];
  logic [SLOTS-1:0]   ent_vld;
  tts_pkg::entry_t    mem_q;
  logic               rd_ok;
  tts_pkg::entry_t    rd;

  tts_pkg::kind_t     op_kind;
  logic [3:0]         op_tid;
  logic [15:0]        op_tag;
  logic [7:0]         default_slice;

  logic [CNT_W-1:0]   scan_idx;
  logic [IDX_W-1:0]   eval_idx;
  logic               eval_vld;
  logic [7:0]         best;
  logic [IDX_W-1:0]   pick;
  tts_pkg::entry_t    pick_entry;
  tts_pkg::entry_t    cur_entry;
  logic               hit;
  logic [IDX_W-1:0]   current_slot;
  logic               current_valid;
  tts_pkg::out_t      pend;

  logic [IDX_W-1:0]   target;
  logic [IDX_W-1:0]   rd_addr;
  logic               is_cur_eval;
  logic [2:0]         st_eff;
  logic               sched_better;
  logic               scan_match;
  logic               wr_en;
  logic [IDX_W-1:0]   wr_addr;
  tts_pkg::entry_t    wr_entry;
  logic               scan_more;

  // Slot that yield, exit, wait and kill act on
  assign target  = (op_kind == tts_pkg::OP_KILL) ? IDX_W'(op_tid) : current_slot;
  assign rd_addr = cmd.scan ? scan_idx[IDX_W-1:0] : target;
  assign rd      = rd_ok ? mem_q : '0;

  assign scan_more = (scan_idx != CNT_W'(SLOTS));

  // Evaluate the slot whose data is back from the memory
  always_comb begin
    is_cur_eval  = current_valid && (eval_idx == current_slot);
    st_eff       = rd.status;
    if (op_kind == tts_pkg::OP_SCHEDULE && is_cur_eval &&
        rd.status == tts_pkg::ST_RUNNING) begin
      st_eff = tts_pkg::ST_READY;
    end
    sched_better = (st_eff == tts_pkg::ST_READY) && (rd.slice > best);
    scan_match   = 1'b0;
    if (eval_vld) begin
      if (op_kind == tts_pkg::OP_CREATE) begin
        scan_match = (rd.status == tts_pkg::ST_UNUSED) ||
                     (rd.status == tts_pkg::ST_STOP);
      end else if (op_kind == tts_pkg::OP_SIGNAL || op_kind == tts_pkg::OP_BROADCAST) begin
        scan_match = (rd.status == tts_pkg::ST_SLEEPING) && (rd.tag == op_tag);
      end
    end
  end

  // Status toward the controller
  always_comb begin
    sts.cur_valid = current_valid;
    sts.kill_ok   = (32'(in_data.thread_id) < 32'(SLOTS));
    sts.scan_end  = !eval_vld && !scan_more;
    sts.scan_stop = scan_match && (op_kind != tts_pkg::OP_BROADCAST);
    sts.hit       = hit;
    sts.out_free  = !out_valid || !out_stall;
  end

  // Select the slot table write
  always_comb begin
    wr_en    = 1'b0;
    wr_addr  = eval_idx;
    wr_entry = rd;
    unique case (cmd.wr_src)
      tts_pkg::WSRC_NONE: begin
        wr_en = 1'b0;
      end
      tts_pkg::WSRC_SCAN: begin
        wr_en           = scan_match;
        wr_entry.status = tts_pkg::ST_READY;
        if (op_kind == tts_pkg::OP_CREATE) begin
          wr_entry.slice = default_slice;
        end
      end
      tts_pkg::WSRC_CUR: begin
        wr_en           = current_valid && (cur_entry.status == tts_pkg::ST_RUNNING);
        wr_addr         = current_slot;
        wr_entry        = cur_entry;
        wr_entry.status = tts_pkg::ST_READY;
      end
      tts_pkg::WSRC_PICK: begin
        wr_en           = 1'b1;
        wr_addr         = pick;
        wr_entry        = pick_entry;
        wr_entry.status = tts_pkg::ST_RUNNING;
      end
      tts_pkg::WSRC_MOD: begin
        wr_en   = 1'b1;
        wr_addr = target;
        unique case (op_kind)
          tts_pkg::OP_YIELD: begin
            wr_entry.status = tts_pkg::ST_READY;
            if (rd.slice != 8'd0) begin
              wr_entry.slice = rd.slice - 8'd1;
            end
          end
          tts_pkg::OP_EXIT, tts_pkg::OP_KILL: begin
            wr_entry.status = tts_pkg::ST_ZOMBIE;
          end
          tts_pkg::OP_WAIT: begin
            wr_entry.status = tts_pkg::ST_SLEEPING;
            wr_entry.tag    = op_tag;
          end
          tts_pkg::OP_CREATE, tts_pkg::OP_SCHEDULE,
          tts_pkg::OP_SIGNAL, tts_pkg::OP_BROADCAST: begin
            wr_entry = rd;
          end
        endcase
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  // Slot table storage and registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_entry;
    end
    mem_q <= mem[rd_addr];
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      ent_vld       <= '0;
      rd_ok         <= 1'b0;
      default_slice <= 8'd10;
      scan_idx      <= '0;
      eval_vld      <= 1'b0;
      hit           <= 1'b0;
      current_slot  <= '0;
      current_valid <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (wr_en) begin
        ent_vld[wr_addr] <= 1'b1;
      end
      rd_ok <= ent_vld[rd_addr];
      if (cfg_we) begin
        default_slice <= cfg_wdata;
      end

      // Advance the scan one slot per cycle
      if (cmd.load) begin
        scan_idx <= '0;
        eval_vld <= 1'b0;
        hit      <= 1'b0;
      end else if (cmd.scan) begin
        eval_vld <= scan_more;
        if (scan_more) begin
          scan_idx <= scan_idx + CNT_W'(1);
        end
        if (eval_vld && op_kind == tts_pkg::OP_SCHEDULE && sched_better) begin
          hit <= 1'b1;
        end
        if (scan_match) begin
          hit <= 1'b1;
        end
      end else begin
        eval_vld <= 1'b0;
      end

      // Track the current thread
      if (cmd.wr_src == tts_pkg::WSRC_PICK) begin
        current_slot  <= pick;
        current_valid <= 1'b1;
      end else if (cmd.wr_src == tts_pkg::WSRC_MOD) begin
        if (op_kind != tts_pkg::OP_KILL) begin
          current_valid <= 1'b0;
        end else if (current_slot == target) begin
          current_valid <= 1'b0;
        end
      end

      // Hold the result until taken
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_kind <= tts_pkg::kind_t'(in_data.kind);
      op_tid  <= in_data.thread_id;
      op_tag  <= in_data.wait_tag;
      best    <= 8'd0;
      pick    <= '0;
    end else if (cmd.scan) begin
      eval_idx <= scan_idx[IDX_W-1:0];
      if (eval_vld && op_kind == tts_pkg::OP_SCHEDULE) begin
        if (sched_better) begin
          best       <= rd.slice;
          pick       <= eval_idx;
          pick_entry <= rd;
        end
        if (is_cur_eval) begin
          cur_entry <= rd;
        end
      end
      if (scan_match && !hit) begin
        pick <= eval_idx;
      end
    end

    if (cmd.res_we) begin
      unique case (cmd.res)
        tts_pkg::RES_OK:       pend <= '{4'd0, 1'b0, tts_pkg::OUT_OK};
        tts_pkg::RES_NONE:     pend <= '{4'd0, 1'b0, tts_pkg::OUT_NONE};
        tts_pkg::RES_NOCUR:    pend <= '{4'd0, 1'b0, tts_pkg::OUT_NOCUR};
        tts_pkg::RES_HIT_EVAL: pend <= '{4'(eval_idx), 1'b1, tts_pkg::OUT_OK};
        tts_pkg::RES_HIT_PICK: pend <= '{4'(pick), 1'b1, tts_pkg::OUT_OK};
        default:               pend <= '{4'd0, 1'b0, tts_pkg::OUT_NONE};
      endcase
    end

    if (cmd.out_load) begin
      out_data <= pend;
    end
  end

  `TTS_CHECK_SAME(a_eval_follows_scan, clk, rst, eval_vld, $past(cmd.scan), "slot evaluated outside a scan")
  `TTS_CHECK_SAME(a_cur_from_pick, clk, rst, $rose(current_valid), $past(cmd.wr_src == tts_pkg::WSRC_PICK), "current thread set without a schedule pick")
  `TTS_CHECK_SAME(a_load_when_free, clk, rst, cmd.out_load, !out_valid || !out_stall, "result register overwritten while stalled")

endmodule

// ----- rtl/thread_table_scheduler_unit.sv -----
// Channel | Direction | Handshake           | Payload
// in      | input     | in_valid/in_stall   | in_data    (kind, thread_id, wait_tag)
// out     | output    | out_valid/out_stall | out_data   (result_thread, found, outcome)
// cfg     | input     | cfg_we              | cfg_wdata  (default_slice)
//
// Create, schedule, signal and broadcast scan one slot per cycle through the single read
// port; schedule then marks the running thread ready and the pick running (S_FIX, S_PICK).
// Yield, exit, wait and kill read then write the slot (S_RD, S_WR); rejects go to S_DONE.
// One transaction is in work at a time; a waiting result does not hold the next one back,
// but a stalled output holds the block once its next result is ready.
// rst is synchronous: table unused, slices and tags zero, no current thread, slice 10.
module thread_table_scheduler_unit #(
  parameter int SLOTS = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  tts_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output tts_pkg::out_t out_data,
  input  logic          cfg_we,
  input  logic [7:0]    cfg_wdata
);

  tts_pkg::cmd_t cmd;
  tts_pkg::sts_t sts;

  tts_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_kind  (in_data.kind),
    .sts      (sts),
    .cmd      (cmd),
    .in_stall (in_stall)
  );

  tts_dp #(
    .SLOTS (SLOTS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .sts       (sts),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule
